// ----- rtl/core/dtm_pkg.sv -----
// Shared types, character codes and command codes for the duration line parser.
// Used by dtm_front, dtm_back and the top level duration_text_to_milliseconds.
package dtm_pkg;

  // Default width of the saturating time arithmetic.
  localparam int DEFAULT_TIME_BITS = 31;
  // Default depth of the internal queues (power of two, at least two).
  localparam int DEFAULT_QUEUE_DEPTH = 2;

  // Width of the emitted total.
  localparam int TOTAL_W = 31;

  // Character codes.
  localparam logic [7:0] CHAR_ZERO    = 8'd48;
  localparam logic [7:0] CHAR_NINE    = 8'd57;
  localparam logic [7:0] CHAR_DASH    = 8'h2d;
  localparam logic [7:0] CHAR_NEWLINE = 8'h0a;
  localparam logic [7:0] CHAR_SPACE   = 8'h20;
  localparam logic [7:0] CHAR_H       = 8'h68;
  localparam logic [7:0] CHAR_M       = 8'h6d;
  localparam logic [7:0] CHAR_S       = 8'h73;

  // Unit scale factors in milliseconds.
  localparam logic [63:0] MS_PER_S    = 64'd1000;
  localparam logic [63:0] MS_PER_MIN  = 64'd60 * 64'd1000;
  localparam logic [63:0] MS_PER_HOUR = 64'd60 * 64'd60 * 64'd1000;

  // Command codes from the classifier to the execution side.
  localparam logic [2:0] OP_DIGIT   = 3'd0;
  localparam logic [2:0] OP_UNIT    = 3'd1;
  localparam logic [2:0] OP_SPACE   = 3'd2;
  localparam logic [2:0] OP_NEWLINE = 3'd3;
  localparam logic [2:0] OP_EXIT    = 3'd4;

  // One classified character.
  typedef struct packed {
    logic [2:0] op;
    logic [7:0] arg;
  } dtm_cmd_t;

  // One result item.
  typedef struct packed {
    logic [TOTAL_W-1:0] total_ms;
    logic               exit_request;
  } dtm_res_t;

endpackage

// ----- rtl/core/dtm_fifo.sv -----
// Small first-in first-out queue of registers used between the parser stages.
// Generic; depends on nothing else.
module dtm_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_push, do_pop;

  assign full     = (count_r == CW'(DEPTH));
  assign empty    = (count_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem_r[rd_ptr_r];

  // Pointer and fill count update; pointers wrap since the depth is a power of two.
  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + AW'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + AW'(1) : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + CW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage needs no reset.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ----- rtl/core/dtm_front.sv -----
// Front end of the duration parser: accepts characters and classifies them.
// Depends on dtm_pkg for character and command codes.
module dtm_front
  import dtm_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_push,
  input  logic [7:0] in_char_code,
  output logic       in_full,
  output logic       cmd_push,
  output dtm_cmd_t   cmd,
  input  logic       cmd_full
);

  logic at_start_r, at_start_nxt;

  assign in_full  = cmd_full;
  assign cmd_push = in_push && !cmd_full;

  // Classify the character; a dash is an exit only as the first character of a line.
  always_comb begin
    cmd.arg = in_char_code;
    if (at_start_r && (in_char_code == CHAR_DASH)) begin
      cmd.op = OP_EXIT;
    end else begin
      case (in_char_code) inside
        CHAR_NEWLINE: cmd.op = OP_NEWLINE;
        CHAR_SPACE:   cmd.op = OP_SPACE;
        [CHAR_ZERO:CHAR_NINE]: begin
          cmd.op  = OP_DIGIT;
          cmd.arg = in_char_code - CHAR_ZERO;
        end
        default:      cmd.op = OP_UNIT;
      endcase
    end
  end

  // Line start tracking: a newline or exit begins a new line, anything else ends it.
  always_comb begin
    at_start_nxt = at_start_r;
    if (cmd_push) begin
      at_start_nxt = (cmd.op == OP_NEWLINE) || (cmd.op == OP_EXIT);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      at_start_r <= 1'b1;
    end else begin
      at_start_r <= at_start_nxt;
    end
  end

endmodule

// ----- rtl/core/dtm_back.sv -----
// Back end of the duration parser: executes classified characters and builds totals.
// Depends on dtm_pkg for command codes, scale factors and the result type.
module dtm_back
  import dtm_pkg::*;
#(
  parameter int TIME_BITS = DEFAULT_TIME_BITS
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     cmd_empty,
  input  dtm_cmd_t cmd,
  output logic     cmd_pop,
  input  logic     res_full,
  output logic     res_push,
  output dtm_res_t res
);

  localparam logic [63:0]          MAXV64    = (64'd1 << TIME_BITS) - 64'd1;
  localparam logic [TIME_BITS-1:0] MAXV      = MAXV64[TIME_BITS-1:0];
  localparam logic [TIME_BITS-1:0] MAX_DIV10 = TIME_BITS'(MAXV64 / 64'd10);

  // Pending number kept alongside its saturated scaled forms.
  logic [TIME_BITS-1:0] num_r, num_nxt;
  logic [TIME_BITS-1:0] sec_r, sec_nxt;
  logic [TIME_BITS-1:0] min_r, min_nxt;
  logic [TIME_BITS-1:0] hr_r, hr_nxt;
  logic [TIME_BITS-1:0] total_r, total_nxt;
  logic [7:0]           letter_r, letter_nxt;
  logic [1:0]           ulen_r, ulen_nxt;

  logic                 makes_result;
  logic [TIME_BITS-1:0] conv;
  logic [TIME_BITS:0]   sum;
  logic [TIME_BITS-1:0] added;
  logic [63:0]          added_wide;
  logic [3:0]           digit;

  // One decimal step of a scaled track: min(10 * t + d * k, MAXV).
  function automatic logic [TIME_BITS-1:0] track_step(input logic [TIME_BITS-1:0] t,
                                                      input logic [3:0] d,
                                                      input logic [63:0] k);
    logic [63:0]          dk;
    logic [TIME_BITS-1:0] dk_sat;
    logic [TIME_BITS-1:0] times10;
    logic [TIME_BITS:0]   acc;
    dk      = {60'd0, d} * k;
    dk_sat  = (dk > MAXV64) ? MAXV : dk[TIME_BITS-1:0];
    times10 = (t << 3) + (t << 1);
    if (t > MAX_DIV10) begin
      return MAXV;
    end
    acc = {1'b0, times10} + {1'b0, dk_sat};
    return acc[TIME_BITS] ? MAXV : acc[TIME_BITS-1:0];
  endfunction

  assign makes_result = (cmd.op == OP_NEWLINE) || (cmd.op == OP_EXIT);
  assign cmd_pop      = !cmd_empty && !(makes_result && res_full);
  assign res_push     = cmd_pop && makes_result;
  assign digit        = cmd.arg[3:0];

  // Unit conversion picks the matching scaled track.
  always_comb begin
    conv = num_r;
    if (ulen_r == 2'd1) begin
      case (letter_r)
        CHAR_H:  conv = hr_r;
        CHAR_M:  conv = min_r;
        CHAR_S:  conv = sec_r;
        default: conv = num_r;
      endcase
    end
  end

  // Saturating add of the converted number to the line total.
  assign sum        = {1'b0, total_r} + {1'b0, conv};
  assign added      = sum[TIME_BITS] ? MAXV : sum[TIME_BITS-1:0];
  assign added_wide = 64'(added);

  always_comb begin
    res.total_ms     = (cmd.op == OP_EXIT) ? '0 : added_wide[TOTAL_W-1:0];
    res.exit_request = (cmd.op == OP_EXIT);
  end

  // State update for the command being executed.
  always_comb begin
    num_nxt    = num_r;
    sec_nxt    = sec_r;
    min_nxt    = min_r;
    hr_nxt     = hr_r;
    total_nxt  = total_r;
    letter_nxt = letter_r;
    ulen_nxt   = ulen_r;
    if (cmd_pop) begin
      case (cmd.op)
        OP_DIGIT: begin
          num_nxt = track_step(num_r, digit, 64'd1);
          sec_nxt = track_step(sec_r, digit, MS_PER_S);
          min_nxt = track_step(min_r, digit, MS_PER_MIN);
          hr_nxt  = track_step(hr_r, digit, MS_PER_HOUR);
        end
        OP_UNIT: begin
          if (ulen_r == 2'd0) begin
            letter_nxt = cmd.arg;
          end
          if (ulen_r != 2'd3) begin
            ulen_nxt = ulen_r + 2'd1;
          end
        end
        OP_SPACE: begin
          total_nxt  = added;
          num_nxt    = '0;
          sec_nxt    = '0;
          min_nxt    = '0;
          hr_nxt     = '0;
          letter_nxt = '0;
          ulen_nxt   = '0;
        end
        OP_NEWLINE, OP_EXIT: begin
          total_nxt  = '0;
          num_nxt    = '0;
          sec_nxt    = '0;
          min_nxt    = '0;
          hr_nxt     = '0;
          letter_nxt = '0;
          ulen_nxt   = '0;
        end
        default: begin
          total_nxt = total_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_r    <= '0;
      sec_r    <= '0;
      min_r    <= '0;
      hr_r     <= '0;
      total_r  <= '0;
      letter_r <= '0;
      ulen_r   <= '0;
    end else begin
      num_r    <= num_nxt;
      sec_r    <= sec_nxt;
      min_r    <= min_nxt;
      hr_r     <= hr_nxt;
      total_r  <= total_nxt;
      letter_r <= letter_nxt;
      ulen_r   <= ulen_nxt;
    end
  end

endmodule

// ----- rtl/core/duration_text_to_milliseconds.sv -----
// Top level of the duration line parser: front end, command queue, back end, result queue.
// Depends on dtm_pkg, dtm_fifo, dtm_front and dtm_back.
//
//   Port group  Direction  Handshake          Content
//   in_*        input      in_push / in_full  one ASCII character per item
//   out_*       output     out_pop / out_empty line total in ms and exit flag
//
// One character is taken per clock cycle when no side stalls.
// A result passes from the command queue through the back end into the registered result
// queue after its newline or dash is taken. The back end's saturating add and decimal step
// are combinational and run once per queued command.
// Reset is synchronous and active low; the first character after it starts a line.
// A stalled output fills the result queue and then the command queue before in_full rises.
module duration_text_to_milliseconds
  import dtm_pkg::*;
#(
  parameter int TIME_BITS   = DEFAULT_TIME_BITS,
  parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  input  logic [7:0]         in_char_code,
  output logic               in_full,
  input  logic               out_pop,
  output logic               out_empty,
  output logic [TOTAL_W-1:0] out_total_ms,
  output logic               out_exit_request
);

  dtm_cmd_t cmd_in, cmd_out;
  dtm_res_t res_in, res_out;
  logic     cmd_push, cmd_full, cmd_pop, cmd_empty;
  logic     res_push, res_full;

  // Character classification.
  dtm_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_push      (in_push),
    .in_char_code (in_char_code),
    .in_full      (in_full),
    .cmd_push     (cmd_push),
    .cmd          (cmd_in),
    .cmd_full     (cmd_full)
  );

  // Queue of classified characters.
  dtm_fifo #(
    .WIDTH ($bits(dtm_cmd_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_cmd_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (cmd_push),
    .push_data (cmd_in),
    .full      (cmd_full),
    .pop       (cmd_pop),
    .pop_data  (cmd_out),
    .empty     (cmd_empty)
  );

  // Number building, unit conversion and line totals.
  dtm_back #(
    .TIME_BITS (TIME_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_empty (cmd_empty),
    .cmd       (cmd_out),
    .cmd_pop   (cmd_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res_in)
  );

  // Queue of finished results.
  dtm_fifo #(
    .WIDTH ($bits(dtm_res_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_res_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_push),
    .push_data (res_in),
    .full      (res_full),
    .pop       (out_pop),
    .pop_data  (res_out),
    .empty     (out_empty)
  );

  assign out_total_ms     = res_out.total_ms;
  assign out_exit_request = res_out.exit_request;

  // The back end never offers a result to a full result queue.
  a_res_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> !res_full)
    else $error("result pushed into a full queue");

  // An accepted character is waiting in the command queue on the next cycle.
  a_cmd_queued: assert property (@(posedge clk) disable iff (!rst_n)
    (in_push && !in_full) |=> !cmd_empty)
    else $error("accepted item missing from the command queue");

  // An exit result always carries a zero total.
  a_exit_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_exit_request) |-> (out_total_ms == '0))
    else $error("exit result with a nonzero total");

  // Commands are only executed when one is waiting.
  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_pop |-> !cmd_empty)
    else $error("command executed from an empty queue");

endmodule
